// ===== src/cluster_allocation_table_engine_defines.svh =====
// Assertion macros for the cluster allocation table engine.
// Define ASSERT_OFF to compile every check away; no other dependencies.
`ifndef CLUSTER_ALLOCATION_TABLE_ENGINE_DEFINES_SVH
`define CLUSTER_ALLOCATION_TABLE_ENGINE_DEFINES_SVH

`ifndef ASSERT_OFF

// Check that cons holds in the same cycle as ante.
`define CATE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cluster table check failed");

// Check that cons holds in the cycle after ante.
`define CATE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cluster table check failed");

`else

`define CATE_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define CATE_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== src/cate_pkg.sv =====
// Shared types and constants of the cluster allocation table engine.
// No dependencies; used by cate_table and cluster_allocation_table_engine.
package cate_pkg;

    localparam int IDX_W = 8;

    localparam logic [7:0] END_MARK      = 8'hFF;
    localparam logic [7:0] FREE_MARK     = 8'h00;
    localparam logic [7:0] RESERVED_LAST = 8'd2;

    localparam logic CFG_CLUSTERS = 1'b0;
    localparam logic CFG_ENABLE   = 1'b1;

    typedef enum logic [2:0] {
        CMD_ALLOC  = 3'd0,
        CMD_LINK   = 3'd1,
        CMD_FREE   = 3'd2,
        CMD_READ   = 3'd3,
        CMD_TAIL   = 3'd4,
        CMD_FORMAT = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_DISABLED = 2'd2,
        ST_RANGE    = 2'd3
    } t_status;

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        logic [7:0]       wr_data;
        logic             clear;
    } t_tbl_req;

endpackage

// ===== src/cate_table.sv =====
// Link table storage: synchronous memory with registered read, per-entry valid bits
// and write-to-read forwarding. Depends on cate_pkg.
module cate_table #(
    parameter int TABLE_DEPTH = 128
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cate_pkg::t_tbl_req i_req,
    output logic [7:0]         o_entry
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic [7:0]             r_mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] r_valid;
    logic [7:0]             r_rd_data;
    logic                   r_rd_valid;
    logic                   r_rd_resv;
    logic                   r_fwd_hit;
    logic [7:0]             r_fwd_data;
    logic [AW-1:0]          rd_idx;
    logic [AW-1:0]          wr_idx;

    assign rd_idx = i_req.rd_addr[AW-1:0];
    assign wr_idx = i_req.wr_addr[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[wr_idx] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data  <= r_mem[rd_idx];
            r_rd_valid <= r_valid[rd_idx];
            r_rd_resv  <= (i_req.rd_addr <= cate_pkg::RESERVED_LAST);
            r_fwd_hit  <= i_req.wr_en && (i_req.wr_addr == i_req.rd_addr);
            r_fwd_data <= i_req.wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_req.clear) begin
            r_valid <= '0;
        end else if (i_req.wr_en) begin
            r_valid[wr_idx] <= 1'b1;
        end
    end

    always_comb begin
        if (r_fwd_hit) begin
            o_entry = r_fwd_data;
        end else if (r_rd_valid) begin
            o_entry = r_rd_data;
        end else begin
            o_entry = r_rd_resv ? cate_pkg::END_MARK : cate_pkg::FREE_MARK;
        end
    end

endmodule

// ===== src/cluster_allocation_table_engine.sv =====
// Cluster allocation table engine, one request at a time. Link, format and refused
// requests go straight to the result; read does one table read; allocate scans the
// table from index 0 for a free entry; free chain and find tail follow the chain.
// Next request accepted the cycle after the result is loaded; a stalled result holds it.
// Synchronous reset restores the formatted table at once (per-entry valid bits),
// sets clusters_in_use to 128 and clears table_enabled.
`include "cluster_allocation_table_engine_defines.svh"

module cluster_allocation_table_engine #(
    parameter int TABLE_DEPTH = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // command[2:0], cluster[10:3], next_cluster[18:11], zero[23:19]
    input  logic [23:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // result_cluster[7:0], link_count[15:8], status[17:16], zero[23:18]
    output logic [23:0] m_axis_tdata
);

    localparam logic [7:0] DEPTH_LIM = 8'(TABLE_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_ALLOC,
        S_FREE,
        S_TAIL,
        S_DONE
    } t_state;

    t_state              r_state, n_state;
    logic [7:0]          r_cur, n_cur;
    logic [7:0]          r_cnt, n_cnt;
    logic [7:0]          r_res, n_res;
    cate_pkg::t_status   r_st, n_st;
    logic [7:0]          r_lim, n_lim;
    logic [7:0]          r_clusters;
    logic                r_enabled;
    logic                r_out_valid, n_out_valid;
    logic [7:0]          r_out_res;
    logic [7:0]          r_out_cnt;
    cate_pkg::t_status   r_out_st;
    logic                load_out;

    cate_pkg::t_tbl_req  tbl_req;
    logic [7:0]          entry;
    cate_pkg::t_cmd      in_cmd;
    logic [7:0]          in_cl;
    logic [7:0]          in_nx;
    logic [7:0]          lim_now;
    logic [7:0]          cur_inc;
    logic                accept;

    assign in_cmd  = cate_pkg::t_cmd'(s_axis_tdata[2:0]);
    assign in_cl   = s_axis_tdata[10:3];
    assign in_nx   = s_axis_tdata[18:11];
    assign lim_now = (r_clusters > DEPTH_LIM) ? DEPTH_LIM : r_clusters;
    assign cur_inc = r_cur + 8'd1;
    assign accept  = s_axis_tvalid && s_axis_tready;

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out_st, r_out_cnt, r_out_res};

    cate_table #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_table (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (tbl_req),
        .o_entry(entry)
    );

    always_comb begin
        n_state  = r_state;
        n_cur    = r_cur;
        n_cnt    = r_cnt;
        n_res    = r_res;
        n_st     = r_st;
        n_lim    = r_lim;
        load_out = 1'b0;
        tbl_req  = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_lim   = lim_now;
                    n_cnt   = 8'd0;
                    n_res   = 8'd0;
                    n_st    = cate_pkg::ST_OK;
                    n_cur   = in_cl;
                    n_state = S_DONE;
                    case (in_cmd)
                        cate_pkg::CMD_ALLOC: begin
                            if (!r_enabled) begin
                                n_st = cate_pkg::ST_DISABLED;
                            end else if (lim_now == 8'd0) begin
                                n_st = cate_pkg::ST_FULL;
                            end else begin
                                n_cur           = 8'd0;
                                tbl_req.rd_en   = 1'b1;
                                tbl_req.rd_addr = 8'd0;
                                n_state         = S_ALLOC;
                            end
                        end
                        cate_pkg::CMD_LINK: begin
                            if (in_cl < lim_now) begin
                                tbl_req.wr_en   = 1'b1;
                                tbl_req.wr_addr = in_cl;
                                tbl_req.wr_data = in_nx;
                            end else begin
                                n_st = cate_pkg::ST_RANGE;
                            end
                        end
                        cate_pkg::CMD_FREE: begin
                            if (in_cl == cate_pkg::END_MARK) begin
                                n_st = cate_pkg::ST_OK;
                            end else if (in_cl >= lim_now) begin
                                n_st = cate_pkg::ST_RANGE;
                            end else begin
                                tbl_req.rd_en   = 1'b1;
                                tbl_req.rd_addr = in_cl;
                                n_state         = S_FREE;
                            end
                        end
                        cate_pkg::CMD_READ: begin
                            if (in_cl < lim_now) begin
                                tbl_req.rd_en   = 1'b1;
                                tbl_req.rd_addr = in_cl;
                                n_state         = S_READ;
                            end else begin
                                n_st = cate_pkg::ST_RANGE;
                            end
                        end
                        cate_pkg::CMD_TAIL: begin
                            if (in_cl < lim_now) begin
                                tbl_req.rd_en   = 1'b1;
                                tbl_req.rd_addr = in_cl;
                                n_state         = S_TAIL;
                            end else begin
                                n_st = cate_pkg::ST_RANGE;
                            end
                        end
                        cate_pkg::CMD_FORMAT: begin
                            tbl_req.clear = 1'b1;
                        end
                        default: begin
                            n_st = cate_pkg::ST_RANGE;
                        end
                    endcase
                end
            end
            S_READ: begin
                n_res   = entry;
                n_state = S_DONE;
            end
            S_ALLOC: begin
                if (entry == cate_pkg::FREE_MARK) begin
                    tbl_req.wr_en   = 1'b1;
                    tbl_req.wr_addr = r_cur;
                    tbl_req.wr_data = cate_pkg::END_MARK;
                    n_res           = r_cur;
                    n_state         = S_DONE;
                end else if (cur_inc >= r_lim) begin
                    n_st    = cate_pkg::ST_FULL;
                    n_state = S_DONE;
                end else begin
                    tbl_req.rd_en   = 1'b1;
                    tbl_req.rd_addr = cur_inc;
                    n_cur           = cur_inc;
                end
            end
            S_FREE: begin
                if (entry == cate_pkg::FREE_MARK) begin
                    n_st    = cate_pkg::ST_RANGE;
                    n_state = S_DONE;
                end else begin
                    tbl_req.wr_en   = 1'b1;
                    tbl_req.wr_addr = r_cur;
                    tbl_req.wr_data = cate_pkg::FREE_MARK;
                    n_res           = r_cur;
                    n_cnt           = r_cnt + 8'd1;
                    if (entry == cate_pkg::END_MARK) begin
                        n_state = S_DONE;
                    end else if (entry >= r_lim) begin
                        n_st    = cate_pkg::ST_RANGE;
                        n_state = S_DONE;
                    end else begin
                        tbl_req.rd_en   = 1'b1;
                        tbl_req.rd_addr = entry;
                        n_cur           = entry;
                    end
                end
            end
            S_TAIL: begin
                if (entry == cate_pkg::END_MARK) begin
                    n_res   = r_cur;
                    n_state = S_DONE;
                end else if (entry == cate_pkg::FREE_MARK || entry >= r_lim
                             || r_cnt >= r_lim) begin
                    n_res   = r_cur;
                    n_st    = cate_pkg::ST_RANGE;
                    n_state = S_DONE;
                end else begin
                    tbl_req.rd_en   = 1'b1;
                    tbl_req.rd_addr = entry;
                    n_cnt           = r_cnt + 8'd1;
                    n_cur           = entry;
                end
            end
            S_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_out_valid = r_out_valid && !m_axis_tready;
        if (load_out) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_clusters  <= 8'd128;
            r_enabled   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                if (i_cfg_index == cate_pkg::CFG_CLUSTERS) begin
                    r_clusters <= i_cfg_wdata;
                end else if (i_cfg_index == cate_pkg::CFG_ENABLE) begin
                    r_enabled <= i_cfg_wdata[0];
                end
            end
        end
        r_cur <= n_cur;
        r_cnt <= n_cnt;
        r_res <= n_res;
        r_st  <= n_st;
        r_lim <= n_lim;
        if (load_out) begin
            r_out_res <= r_res;
            r_out_cnt <= r_cnt;
            r_out_st  <= r_st;
        end
    end

    `CATE_ASSERT_NXT(a_accept_leaves_idle, i_clk, i_rst_n, accept, r_state != S_IDLE)
    `CATE_ASSERT_IMP(a_alloc_in_limit, i_clk, i_rst_n, r_state == S_ALLOC, r_cur < r_lim)
    `CATE_ASSERT_IMP(a_tail_bounded, i_clk, i_rst_n, r_state == S_TAIL, r_cnt <= r_lim)
    `CATE_ASSERT_NXT(a_result_loaded, i_clk, i_rst_n, load_out, m_axis_tvalid)
    `CATE_ASSERT_IMP(a_clear_alone, i_clk, i_rst_n, tbl_req.clear, !(tbl_req.wr_en || tbl_req.rd_en))

endmodule

// ===== tb/tb_cluster_allocation_table_engine.sv =====
// Self-checking testbench for cluster_allocation_table_engine: directed corner requests, then
// random chain, allocate and noise traffic under several register settings and random idling.
// Depends on cate_pkg and the engine RTL only.
module tb_cluster_allocation_table_engine;

    localparam int DEPTH = 128;
    localparam logic [2:0] CMD_SPARE6 = 3'd6;
    localparam logic [2:0] CMD_SPARE7 = 3'd7;
    localparam int N_PHASES = 9;

    typedef struct packed {
        logic [7:0] next_cl;
        logic [7:0] cl;
        logic [2:0] cmd;
    } t_fat_req;

    typedef struct packed {
        cate_pkg::t_status st;
        logic [7:0]        cnt;
        logic [7:0]        res;
    } t_fat_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic        i_cfg_index = 1'b0;
    logic [7:0]  i_cfg_wdata = 8'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // command[2:0], cluster[10:3], next_cluster[18:11], zero[23:19]
    logic [23:0] s_axis_tdata = 24'd0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // result_cluster[7:0], link_count[15:8], status[17:16], zero[23:18]
    logic [23:0] m_axis_tdata;

    logic [7:0]  fat_links [0:DEPTH-1];
    logic [7:0]  cfg_clusters;
    logic        cfg_enabled;

    t_fat_req    requests_waiting [$];
    t_fat_result answers_due [$];
    t_fat_req    cur_req = '0;
    logic        req_live = 1'b0;
    logic        tx_calm = 1'b0;
    logic        rx_calm = 1'b0;
    int          tx_gap = 0;
    int          rx_stall = 0;
    int          requests_queued = 0;
    int          requests_sent = 0;
    int          results_seen = 0;
    int          errors = 0;

    int phase_clusters [N_PHASES] = '{128, 255, 17, 3, 40, 0, 1, 2, 128};
    int phase_enabled  [N_PHASES] = '{1, 1, 1, 1, 0, 1, 1, 1, 1};
    int phase_items    [N_PHASES] = '{480, 240, 240, 120, 150, 60, 60, 60, 210};

    cluster_allocation_table_engine #(.TABLE_DEPTH(DEPTH)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void format_links();
        for (int i = 0; i < DEPTH; i++)
            fat_links[i] = (i <= int'(cate_pkg::RESERVED_LAST)) ? cate_pkg::END_MARK
                                                                : cate_pkg::FREE_MARK;
    endfunction

    function automatic t_fat_result run_fat_command(t_fat_req rq);
        t_fat_result r;
        int lim;
        int cur;
        int v;
        int cnt;
        int i;
        logic done;
        lim = (int'(cfg_clusters) > DEPTH) ? DEPTH : int'(cfg_clusters);
        r.res = 8'd0;
        r.st = cate_pkg::ST_OK;
        cnt = 0;
        done = 1'b0;
        case (rq.cmd)
            cate_pkg::CMD_ALLOC: begin
                if (!cfg_enabled) begin
                    r.st = cate_pkg::ST_DISABLED;
                end else begin
                    r.st = cate_pkg::ST_FULL;
                    for (i = 0; i < lim && !done; i++) begin
                        if (fat_links[i] == cate_pkg::FREE_MARK) begin
                            fat_links[i] = cate_pkg::END_MARK;
                            r.res = 8'(i);
                            r.st = cate_pkg::ST_OK;
                            done = 1'b1;
                        end
                    end
                end
            end
            cate_pkg::CMD_LINK: begin
                if (int'(rq.cl) < lim) fat_links[rq.cl] = rq.next_cl;
                else r.st = cate_pkg::ST_RANGE;
            end
            cate_pkg::CMD_FREE: begin
                cur = int'(rq.cl);
                while (cur != int'(cate_pkg::END_MARK) && !done) begin
                    if (cur >= lim || fat_links[cur] == cate_pkg::FREE_MARK) begin
                        r.st = cate_pkg::ST_RANGE;
                        done = 1'b1;
                    end else begin
                        v = int'(fat_links[cur]);
                        fat_links[cur] = cate_pkg::FREE_MARK;
                        r.res = 8'(cur);
                        cnt++;
                        cur = v;
                    end
                end
            end
            cate_pkg::CMD_READ: begin
                if (int'(rq.cl) < lim) r.res = fat_links[rq.cl];
                else r.st = cate_pkg::ST_RANGE;
            end
            cate_pkg::CMD_TAIL: begin
                if (int'(rq.cl) >= lim) begin
                    r.st = cate_pkg::ST_RANGE;
                end else begin
                    cur = int'(rq.cl);
                    while (!done) begin
                        v = int'(fat_links[cur]);
                        if (v == int'(cate_pkg::END_MARK)) begin
                            r.res = 8'(cur);
                            done = 1'b1;
                        end else if (v == int'(cate_pkg::FREE_MARK) || v >= lim
                                     || cnt >= lim) begin
                            r.res = 8'(cur);
                            r.st = cate_pkg::ST_RANGE;
                            done = 1'b1;
                        end else begin
                            cnt++;
                            cur = v;
                        end
                    end
                end
            end
            cate_pkg::CMD_FORMAT: format_links();
            default: r.st = cate_pkg::ST_RANGE;
        endcase
        r.cnt = 8'(cnt);
        return r;
    endfunction

    task automatic note_mismatch(string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    always @(posedge i_clk) begin : tx_side
        if (!i_rst_n) begin
            req_live = 1'b0;
            tx_gap = 0;
        end else begin
            if (req_live && s_axis_tready) begin
                answers_due.push_back(run_fat_command(cur_req));
                requests_sent++;
                req_live = 1'b0;
                if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
                tx_gap = tx_calm ? 0 : $urandom_range(0, 13);
            end
            if (!req_live) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                end else if (requests_waiting.size() > 0) begin
                    cur_req = requests_waiting.pop_front();
                    req_live = 1'b1;
                end
            end
        end
        s_axis_tvalid <= req_live;
        s_axis_tdata  <= {5'b0, cur_req};
    end

    always @(posedge i_clk) begin : rx_side
        t_fat_result got;
        t_fat_result want;
        if (!i_rst_n) begin
            rx_stall = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = t_fat_result'(m_axis_tdata[17:0]);
                if (answers_due.size() == 0) begin
                    note_mismatch($sformatf("result %0d (0x%06h) with no request outstanding",
                                            results_seen, m_axis_tdata));
                end else begin
                    want = answers_due.pop_front();
                    if (got.res !== want.res)
                        note_mismatch($sformatf("result %0d result_cluster %0d, want %0d",
                                                results_seen, got.res, want.res));
                    if (got.cnt !== want.cnt)
                        note_mismatch($sformatf("result %0d link_count %0d, want %0d",
                                                results_seen, got.cnt, want.cnt));
                    if (got.st !== want.st)
                        note_mismatch($sformatf("result %0d status %0d, want %0d",
                                                results_seen, got.st, want.st));
                end
                results_seen++;
                if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
                rx_stall = rx_calm ? 0 : $urandom_range(0, 13);
            end else if (rx_stall > 0) begin
                rx_stall--;
            end
        end
        m_axis_tready <= i_rst_n && (rx_stall == 0);
    end

    task automatic push_req(logic [2:0] cmd, int cl, int nx);
        t_fat_req rq;
        rq.cmd = cmd;
        rq.cl = 8'(cl);
        rq.next_cl = 8'(nx);
        requests_waiting.push_back(rq);
        requests_queued++;
    endtask

    task automatic write_reg(logic idx, logic [7:0] val);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        if (idx == cate_pkg::CFG_CLUSTERS) cfg_clusters = val;
        else cfg_enabled = val[0];
    endtask

    task automatic wait_drained();
        while (requests_waiting.size() != 0 || req_live || answers_due.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic queue_chain(int lim);
        int perm [DEPTH];
        int span;
        int len;
        int j;
        int t;
        int k;
        int pick;
        span = (lim > 0) ? lim : 1;
        for (k = 0; k < span; k++) perm[k] = k;
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(1, span)
                                           : $urandom_range(1, (span < 6) ? span : 6);
        for (k = 0; k < len; k++) begin
            j = $urandom_range(k, span - 1);
            t = perm[k];
            perm[k] = perm[j];
            perm[j] = t;
        end
        for (k = 0; k + 1 < len; k++) push_req(cate_pkg::CMD_LINK, perm[k], perm[k + 1]);
        pick = $urandom_range(0, 99);
        if (pick < 80)
            push_req(cate_pkg::CMD_LINK, perm[len - 1], int'(cate_pkg::END_MARK));
        else if (pick < 87)
            push_req(cate_pkg::CMD_LINK, perm[len - 1], perm[0]);
        else if (pick < 94)
            push_req(cate_pkg::CMD_LINK, perm[len - 1], int'(cate_pkg::FREE_MARK));
        else
            push_req(cate_pkg::CMD_LINK, perm[len - 1], $urandom_range(0, 255));
        if ($urandom_range(0, 9) != 0) push_req(cate_pkg::CMD_TAIL, perm[0], 0);
        else push_req(cate_pkg::CMD_TAIL, perm[$urandom_range(0, len - 1)], 0);
        if ($urandom_range(0, 3) == 0)
            push_req(cate_pkg::CMD_READ, perm[$urandom_range(0, len - 1)], 0);
        if ($urandom_range(0, 4) < 3) begin
            push_req(cate_pkg::CMD_FREE, perm[0], 0);
            if ($urandom_range(0, 2) == 0) push_req(cate_pkg::CMD_TAIL, perm[0], 0);
        end
    endtask

    task automatic queue_phase(int n);
        int lim;
        int start;
        int pick;
        int burst;
        lim = (int'(cfg_clusters) > DEPTH) ? DEPTH : int'(cfg_clusters);
        start = requests_queued;
        while (requests_queued - start < n) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                queue_chain(lim);
            end else if (pick < 72) begin
                burst = ($urandom_range(0, 9) == 0) ? lim + 2 : $urandom_range(1, 8);
                repeat (burst)
                    push_req(cate_pkg::CMD_ALLOC, $urandom_range(0, 255), $urandom_range(0, 255));
            end else if (pick < 75) begin
                push_req(cate_pkg::CMD_FORMAT, $urandom_range(0, 255), $urandom_range(0, 255));
            end else begin
                push_req(3'($urandom_range(0, 7)),
                         ($urandom_range(0, 1) == 0 && lim > 0) ? $urandom_range(0, lim - 1)
                                                                : $urandom_range(0, 255),
                         $urandom_range(0, 255));
            end
        end
    endtask

    initial begin
        format_links();
        cfg_clusters = 8'd128;
        cfg_enabled = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        push_req(cate_pkg::CMD_ALLOC, 0, 0);
        push_req(cate_pkg::CMD_READ, 0, 0);
        push_req(cate_pkg::CMD_READ, 2, 0);
        push_req(cate_pkg::CMD_READ, 3, 0);
        push_req(cate_pkg::CMD_READ, 127, 0);
        push_req(cate_pkg::CMD_READ, 128, 0);
        push_req(cate_pkg::CMD_READ, 255, 0);
        push_req(cate_pkg::CMD_LINK, 255, 255);
        push_req(cate_pkg::CMD_TAIL, 0, 0);
        push_req(cate_pkg::CMD_TAIL, 200, 0);
        push_req(cate_pkg::CMD_FREE, 255, 0);
        push_req(cate_pkg::CMD_FREE, 3, 0);
        push_req(cate_pkg::CMD_LINK, 3, 4);
        push_req(cate_pkg::CMD_LINK, 4, 127);
        push_req(cate_pkg::CMD_LINK, 127, 255);
        push_req(cate_pkg::CMD_TAIL, 3, 0);
        push_req(cate_pkg::CMD_FREE, 3, 0);
        push_req(cate_pkg::CMD_LINK, 5, 5);
        push_req(cate_pkg::CMD_TAIL, 5, 0);
        push_req(cate_pkg::CMD_FREE, 5, 0);
        push_req(cate_pkg::CMD_LINK, 6, 0);
        push_req(cate_pkg::CMD_TAIL, 6, 0);
        push_req(cate_pkg::CMD_LINK, 7, 200);
        push_req(cate_pkg::CMD_TAIL, 7, 0);
        push_req(cate_pkg::CMD_FREE, 7, 0);
        push_req(CMD_SPARE6, 255, 255);
        push_req(CMD_SPARE7, 0, 0);
        push_req(cate_pkg::CMD_FORMAT, 0, 0);
        wait_drained();

        for (int p = 0; p < N_PHASES; p++) begin
            write_reg(cate_pkg::CFG_CLUSTERS, 8'(phase_clusters[p]));
            write_reg(cate_pkg::CFG_ENABLE, 8'(phase_enabled[p]));
            queue_phase(phase_items[p]);
            wait_drained();
        end

        repeat (150) @(posedge i_clk);
        $display("Checked %0d results for %0d requests over %0d table settings,",
                 results_seen, requests_sent, N_PHASES + 1);
        $display("cluster limits 0 to 255, allocation on and off; %0d mismatches.", errors);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #15_000_000;
        $display("Run timed out with %0d results outstanding.", answers_due.size());
        $display("FAILURE");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+src
src/cate_pkg.sv
src/cate_table.sv
src/cluster_allocation_table_engine.sv
tb/tb_cluster_allocation_table_engine.sv
